/* hdl/sorted_unique_set_table_assert.svh */
// Assertion macros for the sorted unique set table.
// Both macros expect clk and rst to be in scope in the module that uses them.
`ifndef SORTED_UNIQUE_SET_TABLE_ASSERT_SVH
`define SORTED_UNIQUE_SET_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset only
`define SUST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked during reset as well
`define SUST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SUST_ASSERT(label, prop, msg)
`define SUST_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* hdl/sust_pkg.sv */
// Shared types and codes for the sorted unique set table.
// Used by sust_ctrl, sust_dp and the top level; depends on nothing.
package sust_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_REQ,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_POP_RD,
    S_POP_WAIT,
    S_DONE
  } state_t;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_DUP   = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;
  localparam status_t STATUS_FULL  = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic    capture;
    logic    scan_rd;
    logic    scan_next;
    logic    shift_init;
    logic    shift_rd;
    logic    shift_wr;
    logic    write_new;
    logic    pop_rd;
    logic    pop_take;
    logic    set_status;
    status_t status;
    logic    load_out;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_pop;
    logic empty;
    logic full;
    logic cmp_eq;
    logic cmp_gt;
    logic scan_last;
    logic shift_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* hdl/sust_ctrl.sv */
// Controller state machine for the sorted unique set table.
// Depends on sust_pkg; drives the command struct into sust_dp.
module sust_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sust_pkg::dp_stat_t stat,
  output sust_pkg::dp_cmd_t  cmd
);

  sust_pkg::state_t state;
  sust_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sust_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      sust_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = sust_pkg::S_DECODE;
        end
      end
      sust_pkg::S_DECODE: begin
        if (stat.op_pop) begin
          if (stat.empty) begin
            cmd.set_status = 1'b1;
            cmd.status     = sust_pkg::STATUS_EMPTY;
            state_next     = sust_pkg::S_DONE;
          end else begin
            state_next = sust_pkg::S_POP_RD;
          end
        end else if (stat.empty) begin
          state_next = sust_pkg::S_WRITE;
        end else begin
          state_next = sust_pkg::S_SCAN_REQ;
        end
      end
      sust_pkg::S_SCAN_REQ: begin
        cmd.scan_rd = 1'b1;
        state_next  = sust_pkg::S_SCAN_CHK;
      end
      sust_pkg::S_SCAN_CHK: begin
        if (stat.cmp_eq) begin
          cmd.set_status = 1'b1;
          cmd.status     = sust_pkg::STATUS_DUP;
          state_next     = sust_pkg::S_DONE;
        end else if (stat.cmp_gt || stat.scan_last) begin
          if (stat.full) begin
            cmd.set_status = 1'b1;
            cmd.status     = sust_pkg::STATUS_FULL;
            state_next     = sust_pkg::S_DONE;
          end else if (stat.cmp_gt) begin
            // open a gap at the current index
            cmd.shift_init = 1'b1;
            state_next     = sust_pkg::S_SHIFT_RD;
          end else begin
            // append after the largest entry
            cmd.scan_next = 1'b1;
            state_next    = sust_pkg::S_WRITE;
          end
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = sust_pkg::S_SCAN_REQ;
        end
      end
      sust_pkg::S_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = sust_pkg::S_SHIFT_WR;
      end
      sust_pkg::S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = stat.shift_last ? sust_pkg::S_WRITE : sust_pkg::S_SHIFT_RD;
      end
      sust_pkg::S_WRITE: begin
        cmd.write_new  = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = sust_pkg::STATUS_OK;
        state_next     = sust_pkg::S_DONE;
      end
      sust_pkg::S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_next = sust_pkg::S_POP_WAIT;
      end
      sust_pkg::S_POP_WAIT: begin
        cmd.pop_take   = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = sust_pkg::STATUS_OK;
        state_next     = sust_pkg::S_DONE;
      end
      sust_pkg::S_DONE: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = sust_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sust_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/sust_dp.sv */
// Datapath for the sorted unique set table: entry memory, count, scan and
// shift pointers, smallest-value register and output register.
// Depends on sust_pkg and sorted_unique_set_table_assert.svh.
`include "sorted_unique_set_table_assert.svh"
module sust_dp #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  sust_pkg::dp_cmd_t  cmd,
  output sust_pkg::dp_stat_t stat,
  input  logic               in_op,
  input  logic [31:0]        in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output sust_pkg::status_t  out_status,
  output logic [31:0]        out_popped,
  output logic [31:0]        out_min,
  output logic               out_min_valid,
  output logic [4:0]         out_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rd_data;
  logic              op_pop;
  logic [31:0]       val;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     sp;
  logic [31:0]       min_val;
  logic [31:0]       popped;
  sust_pkg::status_t status;

  logic [CW-1:0]     idx_inc;
  logic [CW-1:0]     sp_dec;
  logic [CW-1:0]     count_dec;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;

  assign idx_inc   = idx + CW'(1);
  assign sp_dec    = sp - CW'(1);
  assign count_dec = count - CW'(1);

  always_comb begin
    if (cmd.scan_rd) begin
      rd_addr = idx[AW-1:0];
    end else if (cmd.shift_rd) begin
      rd_addr = sp_dec[AW-1:0];
    end else begin
      rd_addr = count_dec[AW-1:0];
    end
  end

  assign rd_en = cmd.scan_rd | cmd.shift_rd | cmd.pop_rd;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.shift_wr) begin
      mem[sp[AW-1:0]] <= rd_data;
    end else if (cmd.write_new) begin
      mem[idx[AW-1:0]] <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_pop <= in_op;
      val    <= in_value;
      idx    <= '0;
      popped <= '0;
    end else if (cmd.scan_next) begin
      idx <= idx_inc;
    end
    if (cmd.shift_init) begin
      sp <= count;
    end else if (cmd.shift_wr) begin
      sp <= sp_dec;
    end
    if (cmd.write_new && idx == '0) begin
      min_val <= val;
    end
    if (cmd.pop_take) begin
      popped <= rd_data;
    end
    if (cmd.set_status) begin
      status <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.write_new) begin
      count <= count + CW'(1);
    end else if (cmd.pop_rd) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status    <= status;
      out_popped    <= popped;
      out_min       <= (count != '0) ? min_val : 32'd0;
      out_min_valid <= (count != '0);
      out_count     <= 5'(count);
    end
  end

  always_comb begin
    stat.op_pop     = op_pop;
    stat.empty      = (count == '0);
    stat.full       = (count == CW'(DEPTH));
    stat.cmp_eq     = (rd_data == val);
    stat.cmp_gt     = ($signed(rd_data) > $signed(val));
    stat.scan_last  = (idx_inc == count);
    stat.shift_last = (sp == idx_inc);
    stat.out_free   = ~out_valid | out_ready;
  end

  `SUST_ASSERT(a_count_bound, count <= CW'(DEPTH), "entry count above depth")
  `SUST_ASSERT(a_write_room, cmd.write_new |-> count < CW'(DEPTH), "insert into full table")
  `SUST_ASSERT(a_pop_nonempty, cmd.pop_rd |-> count != '0, "pop from empty table")
  `SUST_ASSERT(a_load_free, cmd.load_out |-> (!out_valid || out_ready), "result overwritten")
  `SUST_ASSERT_ALWAYS(a_reset_out, rst |=> !out_valid, "result valid after reset")

endmodule

/* hdl/sorted_unique_set_table.sv */
// Sorted unique set table: an ascending, duplicate-free set of signed
// 32-bit values held in a DEPTH-entry memory.
// Input channel s_axis: tuser carries the operation (0 add, 1 pop largest),
// tdata the value. One transfer in gives exactly one transfer out on m_axis.
// Output m_axis: tuser is the status (ok, duplicate, pop on empty, add when
// full); tdata carries the popped value, the smallest stored value, its
// valid flag and the entry count after the operation.
// An add compares the entries from the smallest up to the first entry not
//   below the value, then moves the entries above it up one at a time to open
//   a gap and writes the value; a duplicate or an add when full ends after
//   the scan. A pop reads and takes the largest entry; a pop on empty reads nothing.
// Both the scan and the shift go through the single read and single write
// port of the entry memory.
// The next item is taken in the cycle after the result enters the output
// register; a stalled receiver holds only the result, and a second result
// waits in the controller until the output register is taken.
// Reset (rst, synchronous) empties the set and drops any pending result;
// the memory is not cleared.
module sorted_unique_set_table #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] popped_value, [63:32] min_value,
                                      // [64] min_valid, [69:65] entry_count, [71:70] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  sust_pkg::dp_cmd_t  cmd;
  sust_pkg::dp_stat_t stat;

  logic [31:0] popped;
  logic [31:0] min_value;
  logic        min_valid;
  logic [4:0]  entry_count;

  sust_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sust_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (s_axis_tuser[0]),
    .in_value      (s_axis_tdata),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_status    (m_axis_tuser),
    .out_popped    (popped),
    .out_min       (min_value),
    .out_min_valid (min_valid),
    .out_count     (entry_count)
  );

  assign m_axis_tdata = {2'b00, entry_count, min_valid, min_value, popped};

endmodule

/* verif/sust_tb_ops_pkg.sv */
// Operation codes for the set table testbench.
// Shared by the checker and the stimulus top; depends on nothing.
package sust_tb_ops_pkg;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_POP = 1'b1;

endpackage

/* verif/sust_set_checker.sv */
// Checker for the sorted unique set table: keeps its own copy of the set,
// predicts one result per input transfer and compares it with the output.
// Depends on sust_pkg (status codes) and sust_tb_ops_pkg (operation codes).
module sust_set_checker #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,   // [31:0] popped, [63:32] min, [64] min valid,
                                      // [69:65] entry count, [71:70] zero
  input  logic [1:0]  m_axis_tuser,   // [1:0] status
  output int          fail_count,
  output int          results_awaited,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sust_pkg::status_t status;
    logic [31:0]       popped;
    logic [31:0]       min_val;
    logic              min_valid;
    logic [4:0]        count;
  } set_result_t;

  logic [31:0] held_vals [DEPTH];
  int          held_count;
  int          mismatches;
  int          checked;
  set_result_t results_due [$];

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 50)
      $display("%0t ns: result %0d, %s: got %0h, expected %0h",
               $time, checked, field, got, want);
    mismatches++;
  endtask

  // Apply one operation to the held set and give the result it produces.
  function automatic set_result_t step_sorted_set(input logic op, input logic [31:0] val);
    set_result_t r;
    int          slot;
    bit          dup;
    r    = '0;
    slot = 0;
    dup  = 1'b0;
    if (op == sust_tb_ops_pkg::OP_ADD) begin
      for (int i = 0; i < held_count; i++)
        if (held_vals[i] == val) dup = 1'b1;
      if (dup) begin
        r.status = sust_pkg::STATUS_DUP;
      end else if (held_count >= DEPTH) begin
        r.status = sust_pkg::STATUS_FULL;
      end else begin
        while (slot < held_count && $signed(held_vals[slot]) < $signed(val)) slot++;
        // open a gap at the sorted place
        for (int i = held_count; i > slot; i--) held_vals[i] = held_vals[i-1];
        held_vals[slot] = val;
        held_count++;
        r.status = sust_pkg::STATUS_OK;
      end
    end else if (held_count == 0) begin
      r.status = sust_pkg::STATUS_EMPTY;
    end else begin
      held_count--;
      r.popped = held_vals[held_count];
      r.status = sust_pkg::STATUS_OK;
    end
    r.min_valid = (held_count > 0);
    r.min_val   = r.min_valid ? held_vals[0] : 32'd0;
    r.count     = 5'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    set_result_t got;
    set_result_t want;
    if (rst) begin
      held_count = 0;
      mismatches = 0;
      checked    = 0;
      results_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        results_due.push_back(step_sorted_set(s_axis_tuser[0], s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
               m_axis_tdata[64], m_axis_tdata[69:65]};
        if (results_due.size() == 0) begin
          report_mismatch("transfer with no result outstanding", 32'(m_axis_tuser), 32'd0);
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.popped !== want.popped)
            report_mismatch("popped value", got.popped, want.popped);
          if (got.min_val !== want.min_val)
            report_mismatch("min value", got.min_val, want.min_val);
          if (got.min_valid !== want.min_valid)
            report_mismatch("min valid", 32'(got.min_valid), 32'(want.min_valid));
          if (got.count !== want.count)
            report_mismatch("entry count", 32'(got.count), 32'(want.count));
          checked++;
        end
      end
    end
    fail_count      <= mismatches;
    results_awaited <= results_due.size();
    results_checked <= checked;
  end

endmodule

/* verif/tb_sorted_unique_set_table.sv */
// Testbench top for the sorted unique set table: clock, reset, stimulus and
// verdict. Depends on sust_tb_ops_pkg, sust_set_checker and the block itself.
module tb_sorted_unique_set_table;
  timeunit 1ns;
  timeprecision 1ps;

  import sust_tb_ops_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1580;
  localparam int DRAIN_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;    // [31:0] value
  logic [0:0]  s_axis_tuser;    // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;    // [31:0] popped, [63:32] min, [64] min valid,
                                // [69:65] entry count, [71:70] zero
  logic [1:0]  m_axis_tuser;    // [1:0] status

  int fail_count;
  int results_awaited;
  int results_checked;
  int send_idle_pct = 9;
  int recv_idle_pct = 81;
  int adds_sent = 0;
  int pops_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sorted_unique_set_table #(.DEPTH(DEPTH)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  sust_set_checker #(.DEPTH(DEPTH)) i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .fail_count      (fail_count),
    .results_awaited (results_awaited),
    .results_checked (results_checked)
  );

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Present one item and hold it until the transfer; valid drops only on an idle gap.
  task automatic send_item(input logic op, input logic [31:0] val);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= val;
    if (op == OP_ADD) adds_sent++;
    else pops_sent++;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin
    logic [31:0] recent_vals [8];
    int          recent_wr;
    int          add_pct;
    logic [31:0] val;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ADD;
    recent_wr     = 0;
    foreach (recent_vals[i]) recent_vals[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pop, extremes, duplicates, fill to full, full and dup-when-full, then pops
    send_item(OP_POP, 32'hFFFF_FFFF);
    send_item(OP_ADD, 32'h7FFF_FFFF);
    send_item(OP_ADD, 32'h8000_0000);
    send_item(OP_ADD, 32'h0000_0000);
    send_item(OP_ADD, 32'hFFFF_FFFF);
    send_item(OP_ADD, 32'h8000_0000);
    send_item(OP_ADD, 32'h7FFF_FFFF);
    for (int i = 0; i < DEPTH - 4; i++)
      send_item(OP_ADD, 32'h0246_8ACE + i * 32'h1357_9BDF);
    send_item(OP_ADD, 32'h1234_5678);
    send_item(OP_ADD, 32'h0000_0000);
    send_item(OP_POP, 32'h0000_0000);
    send_item(OP_POP, 32'h5555_5555);

    // random: alternate filling, balanced and draining stretches
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 81;
        recv_idle_pct <= 9;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      case ((n / 64) % 3)
        0:       add_pct = 85;
        1:       add_pct = 50;
        default: add_pct = 15;
      endcase
      if ($urandom_range(99) < add_pct) begin
        case ($urandom_range(9))
          0, 1, 2, 3: val = $urandom;
          4, 5, 6:    val = 32'($urandom_range(16)) - 32'd8;
          7, 8:       val = recent_vals[$urandom_range(7)];
          default: begin
            case ($urandom_range(3))
              0:       val = 32'h8000_0000;
              1:       val = 32'h7FFF_FFFF;
              2:       val = 32'h0000_0000;
              default: val = 32'hFFFF_FFFF;
            endcase
          end
        endcase
        recent_vals[recent_wr] = val;
        recent_wr = (recent_wr + 1) % 8;
        send_item(OP_ADD, val);
      end else begin
        send_item(OP_POP, $urandom);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (results_awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d adds and %0d pops across three pacing phases; %0d results checked.",
             adds_sent, pops_sent, results_checked);
    if (fail_count == 0 && results_awaited == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Run timed out with %0d results outstanding.", results_awaited);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
